FILE: rtl/lsbpk_pkg.sv
// ----------------------------------------------------------------------------
// LSB-first pair bit packer package
// Shared constants and types for the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package lsbpk_pkg;

  localparam int MAX_CODE_BITS = 16;
  localparam int SYM_BITS      = 8;
  localparam int CODE_W        = 16;
  localparam int LEN_W         = 5;
  localparam int PEND_W        = 7;
  localparam int PCNT_W        = 3;
  localparam int ACC_W         = PEND_W + MAX_CODE_BITS + SYM_BITS;
  localparam int MAX_BYTES     = 3;
  localparam int DATA_W        = MAX_BYTES * 8;
  localparam int NB_W          = 2;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic REQ_PAIR  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [NB_W-1:0]   nbytes;
  } lsbpk_entry_t;

endpackage

FILE: rtl/lsbpk_front.sv
// ----------------------------------------------------------------------------
// LSB-first pair bit packer front end
// Accepts items, merges them with the pending bits and queues whole bytes.
// ----------------------------------------------------------------------------
module lsbpk_front import lsbpk_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [CODE_W-1:0]   in_code_value,
  input  logic [LEN_W-1:0]    in_code_len,
  input  logic [7:0]          in_symbol_byte,
  input  logic                q_full,
  output logic                q_push,
  output lsbpk_entry_t        q_entry
);

  logic [PEND_W-1:0] pend_bits_r, pend_bits_nxt;
  logic [PCNT_W-1:0] pend_cnt_r, pend_cnt_nxt;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W:0]   code_mask;
  logic [CODE_W-1:0] code_clip;
  logic [LEN_W-1:0]  sym_shift;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  acc_rest;
  logic [LEN_W-1:0]  total;
  logic [NB_W-1:0]   nbytes;
  logic              accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    len_sat = (in_code_len > LEN_W'(MAX_CODE_BITS)) ? LEN_W'(MAX_CODE_BITS) : in_code_len;
    code_mask = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);
    code_clip = in_code_value & code_mask[CODE_W-1:0];
    sym_shift = LEN_W'(pend_cnt_r) + len_sat;
    acc = ACC_W'(pend_bits_r)
        | (ACC_W'(code_clip) << pend_cnt_r)
        | (ACC_W'(in_symbol_byte) << sym_shift);
    total = LEN_W'(pend_cnt_r) + len_sat + LEN_W'(SYM_BITS);
    nbytes = total[LEN_W-1:3];
    acc_rest = acc >> {nbytes, 3'b000};
    if (in_req_type == REQ_FLUSH) begin
      q_entry.data   = DATA_W'(pend_bits_r);
      q_entry.nbytes = NB_W'(1);
      pend_bits_nxt  = '0;
      pend_cnt_nxt   = '0;
    end else begin
      q_entry.data   = acc[DATA_W-1:0];
      q_entry.nbytes = nbytes;
      pend_bits_nxt  = acc_rest[PEND_W-1:0];
      pend_cnt_nxt   = total[PCNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_bits_r <= '0;
      pend_cnt_r  <= '0;
    end else if (accept) begin
      pend_bits_r <= pend_bits_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

FILE: rtl/lsbpk_fifo.sv
// ----------------------------------------------------------------------------
// LSB-first pair bit packer queue
// Short queue of byte groups between the front end and the back end.
// ----------------------------------------------------------------------------
module lsbpk_fifo import lsbpk_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  lsbpk_entry_t push_entry,
  output logic         full,
  input  logic         pop,
  output logic         not_empty,
  output lsbpk_entry_t head
);

  lsbpk_entry_t          mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + FIFO_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + FIFO_PTR_W'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/lsbpk_back.sv
// ----------------------------------------------------------------------------
// LSB-first pair bit packer back end
// Takes byte groups from the queue and sends one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
module lsbpk_back import lsbpk_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_not_empty,
  input  lsbpk_entry_t q_head,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_byte,
  output logic         out_last_of_run
);

  logic              cur_valid_r, cur_valid_nxt;
  logic [DATA_W-1:0] cur_data_r, cur_data_nxt;
  logic [NB_W-1:0]   cur_rem_r, cur_rem_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_byte_r;
  logic              out_last_r;
  logic              take;
  logic              cur_done;

  assign take     = cur_valid_r && (!out_valid_r || !out_stall);
  assign cur_done = take && (cur_rem_r == NB_W'(1));
  assign q_pop    = q_not_empty && (!cur_valid_r || cur_done);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    cur_data_nxt  = cur_data_r;
    cur_rem_nxt   = cur_rem_r;
    if (q_pop) begin
      cur_valid_nxt = 1'b1;
      cur_data_nxt  = q_head.data;
      cur_rem_nxt   = q_head.nbytes;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (take) begin
      cur_data_nxt = cur_data_r >> 8;
      cur_rem_nxt  = cur_rem_r - NB_W'(1);
    end
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte_r <= cur_data_r[7:0];
      out_last_r <= (cur_rem_r == NB_W'(1));
    end
    cur_data_r <= cur_data_nxt;
    cur_rem_r  <= cur_rem_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last_of_run = out_last_r;

endmodule

FILE: rtl/lsb_first_pair_bit_packer_top.sv
// ----------------------------------------------------------------------------
// LSB-first pair bit packer top level
// Packs code and symbol pairs into bytes, least significant bit first.
// ----------------------------------------------------------------------------
// The first byte of an item is registered in the queue, then in the back end's
// current group register, then in the output register before it is presented.
// Throughput: one byte per cycle at the output register while out_stall is low;
// an item makes one to three bytes, and the input takes one item per cycle while
// the four-entry queue has room.
// Reset: synchronous reset clears the pending bits, the queue and all valids.
module lsb_first_pair_bit_packer_top import lsbpk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [CODE_W-1:0] in_code_value,
  input  logic [LEN_W-1:0]  in_code_len,
  input  logic [7:0]        in_symbol_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_byte,
  output logic              out_last_of_run
);

  logic         q_full;
  logic         q_push;
  lsbpk_entry_t q_entry;
  logic         q_pop;
  logic         q_not_empty;
  lsbpk_entry_t q_head;

  lsbpk_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_code_value  (in_code_value),
    .in_code_len    (in_code_len),
    .in_symbol_byte (in_symbol_byte),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_entry        (q_entry)
  );

  lsbpk_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  lsbpk_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_last_of_run (out_last_of_run)
  );

endmodule
